// File: hdl/bbt_pkg.sv
package bbt_pkg;

  localparam int MAX_SIZE_DEF   = 64;
  localparam int MAX_LEVELS_DEF = 6;
  localparam int COEF_BITS_DEF  = 16;

  // products per pair: 4 terms x 2 halves, plus one drain step
  localparam logic [3:0] MUL_LAST = 4'd8;
  // coefficient sweep: 4 entries per lane, plus one for read latency
  localparam logic [3:0] COEF_LAST = 4'd8;

  typedef enum logic [1:0] {
    MAT_A   = 2'd0,
    MAT_B   = 2'd1,
    MAT_C   = 2'd2,
    MAT_DIV = 2'd3
  } mat_sel_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_MUL,
    ST_DIV,
    ST_DIVW,
    ST_WR0,
    ST_WR1,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       we;
    logic       wr_ext;
    logic       wr_y1;
    logic       cap_x0;
    logic       cap_x1;
    logic       mul_en;
    logic [3:0] mstep;
    logic       div_start;
  } lane_ctrl_t;

endpackage

// File: hdl/bbt_ram.sv
module bbt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bbt_div.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
module bbt_div #(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [63:0]   quotient
);

  logic          run;
  logic [6:0]    cnt;
  logic          neg;
  logic [63:0]   qd;
  logic [DW-1:0] rem;
  logic [DW-1:0] dm;
  logic [DW:0]   rsh;
  logic [DW:0]   rdiff;
  logic [DW:0]   dneg;

  assign rsh   = {rem, qd[63]};
  assign rdiff = rsh - {1'b0, dm};
  assign dneg  = {1'b0, ~divisor} + {{DW{1'b0}}, 1'b1};
  assign quotient = neg ? (64'd0 - qd) : qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[63] ^ divisor[DW-1];
      qd  <= dividend[63] ? (64'd0 - dividend) : dividend;
      dm  <= divisor[DW-1] ? dneg[DW-1:0] : divisor;
      rem <= '0;
    end else if (run) begin
      if (!rdiff[DW]) begin
        rem <= rdiff[DW-1:0];
        qd  <= {qd[62:0], 1'b1};
      end else begin
        rem <= rsh[DW-1:0];
        qd  <= {qd[62:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/bbt_lane.sv
// one vector lane: element memory, shared multiplier, pair accumulators, dividers
module bbt_lane #(
  parameter int DEPTH = 64,
  parameter int CW    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bbt_pkg::lane_ctrl_t      ctrl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic [63:0]              ext_data,
  input  logic [3:0][CW-1:0]       coef,
  input  logic [CW-1:0]            divisor,
  output logic [63:0]              rdata,
  output logic                     div_done
);

  localparam int PW = CW + 33;

  logic [63:0]          wdata;
  logic [63:0]          x0, x1, y0, y1;
  logic [1:0]           term;
  logic [63:0]          xsel;
  logic signed [32:0]   xh;
  logic signed [CW-1:0] cf;
  logic signed [PW-1:0] prod_next;
  logic signed [PW-1:0] prod;
  logic [2:0]           pstep;
  logic                 pvalid;
  logic [63:0]          pval;
  logic [63:0]          q0, q1;
  logic                 done1;

  assign wdata = ctrl.wr_ext ? ext_data : (ctrl.wr_y1 ? y1 : y0);

  bbt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (ctrl.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // term t: coefficient t times x[t[0]], into y[t[1]]; mstep[0] picks the half
  assign term = ctrl.mstep[2:1];
  assign xsel = term[0] ? x1 : x0;
  assign xh   = ctrl.mstep[0] ? $signed({xsel[63], xsel[63:32]})
                              : $signed({1'b0, xsel[31:0]});
  assign cf   = $signed(coef[term]);
  assign prod_next = cf * xh;

  assign pval = pstep[0] ? {prod[31:0], 32'd0} : 64'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= ctrl.mul_en && (ctrl.mstep < bbt_pkg::MUL_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap_x0) begin
      x0 <= rdata;
    end
    if (ctrl.cap_x1) begin
      x1 <= rdata;
    end
    prod  <= prod_next;
    pstep <= ctrl.mstep[2:0];
    if (ctrl.mul_en && ctrl.mstep == 4'd0) begin
      y0 <= '0;
      y1 <= '0;
    end else if (pvalid) begin
      if (pstep[2]) begin
        y1 <= y1 + pval;
      end else begin
        y0 <= y0 + pval;
      end
    end else if (div_done) begin
      y0 <= q0;
      y1 <= q1;
    end
  end

  bbt_div #(.DW(CW)) u_div0 (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (y0),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (q0)
  );

  bbt_div #(.DW(CW)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (y1),
    .divisor  (divisor),
    .done     (done1),
    .quotient (q1)
  );

endmodule

// File: hdl/binary_butterfly_transform.sv
// Loads take one item per cycle while idle; the last data beat starts the transform.
// Per level: a coefficient fetch, then per pair a forward pass (read, 8 partial
// products on the shared lane multiplier, write back), plus in inverse mode with a
// nonzero divisor a 64-step bit-serial divide before write back.
// Then N results, one per cycle. Throughput is one transform per pass.
// rst is synchronous: clears control, load count, error flag, divisors to 1.
module binary_butterfly_transform #(
  parameter int MAX_SIZE   = bbt_pkg::MAX_SIZE_DEF,
  parameter int MAX_LEVELS = bbt_pkg::MAX_LEVELS_DEF,
  parameter int COEF_BITS  = bbt_pkg::COEF_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [2:0]         level,
  input  logic [1:0]         matrix_sel,
  input  logic [1:0]         entry,
  input  logic signed [15:0] coef_value,
  input  logic signed [31:0] data_a,
  input  logic signed [31:0] data_b,
  input  logic               last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data,
  output logic               done,
  output logic [5:0]         index,
  output logic signed [63:0] out_a,
  output logic signed [63:0] out_b,
  output logic               div_error,
  output logic               out_last
);

  localparam int CW     = (COEF_BITS < 16) ? COEF_BITS : 16;
  localparam int AW     = $clog2(MAX_SIZE);
  localparam int LOG    = $clog2(MAX_SIZE + 1) - 1;
  localparam int LVMAX  = (MAX_LEVELS < LOG) ? MAX_LEVELS : LOG;
  localparam int CDEPTH = MAX_LEVELS * 12;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int KW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  bbt_pkg::state_t state, state_next;

  logic              mode;
  logic [2:0]        size_log2;
  logic [AW:0]       load_count;
  logic              error_seen;
  logic [CW-1:0]     div_r [MAX_LEVELS];
  logic [3:0][CW-1:0] ca, cb;
  logic [3:0]        cs, mstep;
  logic [AW-1:0]     j, i;
  logic [2:0]        k;
  logic              emit_v, emit_last;
  logic [AW-1:0]     emit_idx;

  logic [2:0]        lv;
  logic [AW:0]       n;
  logic [AW-1:0]     lnmask, ln, p0, p1;
  logic [CW-1:0]     cur_div;
  logic              use_div, last_pair, last_level, accept, load_ok;
  logic [2:0]        cap_idx;
  logic [1:0]        rd_sel;
  logic [CAW-1:0]    coef_waddr, coef_raddr;
  logic [CW-1:0]     coef_rdata;
  logic              coef_we;

  bbt_pkg::lane_ctrl_t ctrl_a, ctrl_b;
  logic [AW-1:0]     waddr, raddr;
  logic [63:0]       rd_a, rd_b;
  logic              done_a, done_b;

  assign lv   = (size_log2 > 3'(LVMAX)) ? 3'(LVMAX) : size_log2;
  assign n    = (AW + 1)'(1) << lv;
  assign ln   = AW'(1) << k;
  assign lnmask = ln - AW'(1);
  assign p0   = ((j & ~lnmask) << 1) | (j & lnmask);
  assign p1   = p0 | ln;
  assign cur_div    = div_r[k[KW-1:0]];
  assign use_div    = mode && (cur_div != '0);
  assign last_pair  = ((AW + 1)'(j) == (n >> 1) - (AW + 1)'(1));
  assign last_level = (k == lv - 3'd1);
  assign accept     = start && !busy;
  assign load_ok    = load_count < n;

  assign busy = (state != bbt_pkg::ST_IDLE) || emit_v;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      size_log2 <= 3'd6;
    end else if (cfg_we) begin
      unique case (bbt_pkg::reg_idx_t'(cfg_index))
        bbt_pkg::REG_MODE: mode      <= cfg_data[0];
        bbt_pkg::REG_SIZE: size_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient store
  assign coef_we    = accept && !kind && (32'(level) < MAX_LEVELS) &&
                      (matrix_sel != bbt_pkg::MAT_DIV);
  assign coef_waddr = CAW'((32'(level) * 3 + 32'(matrix_sel)) * 4 + 32'(entry));
  assign rd_sel     = cs[2] ? bbt_pkg::MAT_B : (mode ? bbt_pkg::MAT_C : bbt_pkg::MAT_A);
  assign coef_raddr = CAW'((32'(k) * 3 + 32'(rd_sel)) * 4 + 32'(cs[1:0]));
  assign cap_idx    = 3'(cs - 4'd1);

  bbt_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value[CW-1:0]),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_LEVELS; d++) begin
        div_r[d] <= CW'(1);
      end
    end else if (accept && !kind && (32'(level) < MAX_LEVELS) &&
                 (matrix_sel == bbt_pkg::MAT_DIV)) begin
      div_r[level[KW-1:0]] <= coef_value[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == bbt_pkg::ST_COEF && cs != 4'd0) begin
      if (cap_idx[2]) begin
        cb[cap_idx[1:0]] <= coef_rdata;
      end else begin
        ca[cap_idx[1:0]] <= coef_rdata;
      end
    end
  end

  // sequencer state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bbt_pkg::ST_IDLE;
      load_count <= '0;
      error_seen <= 1'b0;
      cs         <= '0;
      mstep      <= '0;
      j          <= '0;
      k          <= '0;
      i          <= '0;
      emit_v     <= 1'b0;
      emit_last  <= 1'b0;
    end else begin
      state     <= state_next;
      emit_v    <= (state == bbt_pkg::ST_EMIT);
      emit_last <= ((AW + 1)'(i) == n - (AW + 1)'(1));
      cs    <= (state == bbt_pkg::ST_COEF) ? cs + 4'd1 : '0;
      mstep <= (state == bbt_pkg::ST_MUL) ? mstep + 4'd1 : '0;
      i     <= (state == bbt_pkg::ST_EMIT) ? i + AW'(1) : '0;
      if (state == bbt_pkg::ST_IDLE) begin
        j <= '0;
        k <= '0;
        if (accept && kind) begin
          if (last) begin
            load_count <= '0;
          end else if (load_ok) begin
            load_count <= load_count + (AW + 1)'(1);
          end
        end
      end
      if (state == bbt_pkg::ST_COEF && cs == 4'd0 && mode && cur_div == '0) begin
        error_seen <= 1'b1;
      end
      if (state == bbt_pkg::ST_WR1) begin
        if (last_pair) begin
          j <= '0;
          k <= k + 3'd1;
        end else begin
          j <= j + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_idx <= i;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbt_pkg::ST_IDLE:
        if (accept && kind && last) begin
          state_next = (lv == 3'd0) ? bbt_pkg::ST_EMIT : bbt_pkg::ST_COEF;
        end
      bbt_pkg::ST_COEF:
        if (cs == bbt_pkg::COEF_LAST) state_next = bbt_pkg::ST_RD0;
      bbt_pkg::ST_RD0: state_next = bbt_pkg::ST_RD1;
      bbt_pkg::ST_RD1: state_next = bbt_pkg::ST_RD2;
      bbt_pkg::ST_RD2: state_next = bbt_pkg::ST_MUL;
      bbt_pkg::ST_MUL:
        if (mstep == bbt_pkg::MUL_LAST) begin
          state_next = use_div ? bbt_pkg::ST_DIV : bbt_pkg::ST_WR0;
        end
      bbt_pkg::ST_DIV:  state_next = bbt_pkg::ST_DIVW;
      bbt_pkg::ST_DIVW:
        if (done_a) state_next = bbt_pkg::ST_WR0;
      bbt_pkg::ST_WR0: state_next = bbt_pkg::ST_WR1;
      bbt_pkg::ST_WR1:
        if (!last_pair) begin
          state_next = bbt_pkg::ST_RD0;
        end else begin
          state_next = last_level ? bbt_pkg::ST_EMIT : bbt_pkg::ST_COEF;
        end
      bbt_pkg::ST_EMIT:
        if ((AW + 1)'(i) == n - (AW + 1)'(1)) state_next = bbt_pkg::ST_IDLE;
      default: state_next = bbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_a = '0;
    waddr  = p0;
    raddr  = p0;
    unique case (state)
      bbt_pkg::ST_IDLE: begin
        ctrl_a.we     = accept && kind && load_ok;
        ctrl_a.wr_ext = 1'b1;
        waddr         = load_count[AW-1:0];
      end
      bbt_pkg::ST_RD1: begin
        raddr         = p1;
        ctrl_a.cap_x0 = 1'b1;
      end
      bbt_pkg::ST_RD2: ctrl_a.cap_x1 = 1'b1;
      bbt_pkg::ST_MUL: begin
        ctrl_a.mul_en = 1'b1;
        ctrl_a.mstep  = mstep;
      end
      bbt_pkg::ST_DIV: ctrl_a.div_start = 1'b1;
      bbt_pkg::ST_WR0: ctrl_a.we = 1'b1;
      bbt_pkg::ST_WR1: begin
        ctrl_a.we    = 1'b1;
        ctrl_a.wr_y1 = 1'b1;
        waddr        = p1;
      end
      bbt_pkg::ST_EMIT: raddr = i;
      default: ;
    endcase
    // lane b stays untouched by the inverse transform and never divides
    ctrl_b           = ctrl_a;
    ctrl_b.div_start = 1'b0;
    if (mode && state != bbt_pkg::ST_IDLE) begin
      ctrl_b.we = 1'b0;
    end
  end

  bbt_lane #(.DEPTH(MAX_SIZE), .CW(CW)) u_lane_a (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_a),
    .waddr    (waddr),
    .raddr    (raddr),
    .ext_data (64'(data_a)),
    .coef     (ca),
    .divisor  (cur_div),
    .rdata    (rd_a),
    .div_done (done_a)
  );

  bbt_lane #(.DEPTH(MAX_SIZE), .CW(CW)) u_lane_b (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_b),
    .waddr    (waddr),
    .raddr    (raddr),
    .ext_data (64'(data_b)),
    .coef     (cb),
    .divisor  (cur_div),
    .rdata    (rd_b),
    .div_done (done_b)
  );

  // merge: result beat from both lanes
  assign done      = emit_v;
  assign index     = 6'(emit_idx);
  assign out_a     = rd_a;
  assign out_b     = mode ? 64'sd0 : rd_b;
  assign div_error = error_seen;
  assign out_last  = emit_last;

endmodule

// File: hdl/bbt_checker.sv
module bbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       done,
  input logic [5:0] index,
  input logic       out_last
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat while not busy");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    done && !out_last |=> done)
    else $error("gap inside result burst");

  a_idx: assert property (@(posedge clk) disable iff (rst)
    done && !out_last |=> index == $past(index) + 6'd1)
    else $error("result index not consecutive");

  a_end: assert property (@(posedge clk) disable iff (rst)
    done && out_last |=> !done)
    else $error("result beat after last");

endmodule

bind binary_butterfly_transform bbt_checker u_bbt_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .done     (done),
  .index    (index),
  .out_last (out_last)
);

// File: dv/bbt_checker.sv
`timescale 1ns / 100ps
module bbt_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               kind,
  input  logic [2:0]         level,
  input  logic [1:0]         matrix_sel,
  input  logic [1:0]         entry,
  input  logic signed [15:0] coef_value,
  input  logic signed [31:0] data_a,
  input  logic signed [31:0] data_b,
  input  logic               last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic               done,
  input  logic [5:0]         index,
  input  logic signed [63:0] out_a,
  input  logic signed [63:0] out_b,
  input  logic               div_error,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [5:0]  idx;
    logic [63:0] a;
    logic [63:0] b;
    logic        err;
    logic        lst;
  } elem_t;

  logic [63:0] coefs [0:5][0:2][0:3];
  logic [63:0] divs [0:5];
  logic [63:0] va [0:63];
  logic [63:0] vb [0:63];
  int          fill;
  logic        err_flag;
  logic        inv_mode;
  logic [2:0]  lg_size;
  elem_t       elems_due[$];

  assign pending = elems_due.size();

  function automatic logic [63:0] tdiv(logic [63:0] x, logic [63:0] d);
    if (d == '1) return -x;
    return $signed(x) / $signed(d);
  endfunction

  task automatic run_level(bit use_b, int k, int n);
    logic [63:0] x0, x1, y0, y1, d;
    int ln, sel;
    ln = 1 << k;
    sel = inv_mode ? bbt_pkg::MAT_C : (use_b ? bbt_pkg::MAT_B : bbt_pkg::MAT_A);
    d = divs[k];
    for (int l = 0; l < n; l += 2 * ln)
      for (int i = 0; i < ln; i++) begin
        x0 = use_b ? vb[l+i] : va[l+i];
        x1 = use_b ? vb[l+ln+i] : va[l+ln+i];
        y0 = coefs[k][sel][0] * x0 + coefs[k][sel][1] * x1;
        y1 = coefs[k][sel][2] * x0 + coefs[k][sel][3] * x1;
        if (inv_mode && d != 0) begin
          y0 = tdiv(y0, d);
          y1 = tdiv(y1, d);
        end
        if (use_b) begin
          vb[l+i] = y0; vb[l+ln+i] = y1;
        end else begin
          va[l+i] = y0; va[l+ln+i] = y1;
        end
      end
  endtask

  task automatic predict_beat();
    int lv, n;
    elem_t e;
    lv = (lg_size > 6) ? 6 : lg_size;
    n = 1 << lv;
    if (!kind) begin
      if (level < 6) begin
        if (matrix_sel == bbt_pkg::MAT_DIV) divs[level] = {{48{coef_value[15]}}, coef_value};
        else coefs[level][matrix_sel][entry] = {{48{coef_value[15]}}, coef_value};
      end
      return;
    end
    if (fill < n) begin
      va[fill] = {{32{data_a[31]}}, data_a};
      vb[fill] = {{32{data_b[31]}}, data_b};
      fill++;
    end
    if (!last) return;
    for (int k = 0; k < lv; k++) begin
      if (inv_mode) begin
        if (divs[k] == 0) err_flag = 1;
        run_level(0, k, n);
      end else begin
        run_level(0, k, n);
        run_level(1, k, n);
      end
    end
    for (int i = 0; i < n; i++) begin
      e.idx = 6'(i); e.a = va[i]; e.b = inv_mode ? 64'd0 : vb[i];
      e.err = err_flag; e.lst = (i == n - 1);
      elems_due.push_back(e);
    end
    fill = 0;
  endtask

  task automatic check_elem();
    elem_t e;
    if (elems_due.size() == 0) begin
      $display("%0t: unexpected element idx %0d a %h", $time, index, out_a);
      fail_count++;
      return;
    end
    e = elems_due.pop_front();
    if (index !== e.idx || out_a !== e.a || out_b !== e.b || div_error !== e.err ||
        out_last !== e.lst) begin
      $display("%0t: mismatch exp idx %0d a %h b %h err %b last %b", $time,
               e.idx, e.a, e.b, e.err, e.lst);
      $display("%0t:          got idx %0d a %h b %h err %b last %b", $time,
               index, out_a, out_b, div_error, out_last);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) divs[k] = 1;
      fill = 0; err_flag = 0; inv_mode = 0; lg_size = 6;
      elems_due.delete();
    end else begin
      if (done) check_elem();
      if (cfg_we) begin
        if (cfg_index == bbt_pkg::REG_MODE) inv_mode = cfg_data[0];
        else lg_size = cfg_data;
      end
      if (start && !busy) predict_beat();
    end
  end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  logic clk = 0, rst = 1;
  logic start = 0, kind = 0, last = 0, cfg_we = 0, cfg_index = 0;
  logic [2:0] level = 0, cfg_data = 0;
  logic [1:0] matrix_sel = 0, entry = 0;
  logic signed [15:0] coef_value = 0;
  logic signed [31:0] data_a = 0, data_b = 0;
  logic busy, done, div_error, out_last;
  logic [5:0] index;
  logic signed [63:0] out_a, out_b;
  int fail_count, pending;
  int beats;
  bit quiet;

  always #1 clk = ~clk;

  binary_butterfly_transform dut (.*);
  bbt_scoreboard chk (.*);

  task automatic send(logic k, logic [2:0] lv, logic [1:0] ms, logic [1:0] en,
                      logic [15:0] cv, logic [31:0] da, logic [31:0] db, logic ls);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1; kind <= k; level <= lv; matrix_sel <= ms; entry <= en;
    coef_value <= cv; data_a <= da; data_b <= db; last <= ls;
    do @(posedge clk); while (busy);
    beats++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(bbt_pkg::reg_idx_t r, logic [2:0] v);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // coefficients kept small unless wide is set, so values stay readable
  task automatic load_coefs(bit wide);
    logic [15:0] v;
    for (int lv = 0; lv < 6; lv++)
      for (int m = 0; m < 3; m++)
        for (int e = 0; e < 4; e++) begin
          v = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 6)) - 3);
          send(0, 3'(lv), 2'(m), 2'(e), v, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
  endtask

  task automatic load_divs(bit allow_zero);
    for (int lv = 0; lv < 6; lv++)
      send(0, 3'(lv), bbt_pkg::MAT_DIV, 2'($urandom),
           allow_zero && $urandom_range(0, 3) == 0 ? 16'd0 :
           16'($signed($urandom_range(0, 4)) - 2) | 16'd1, 0, 0, 0);
  endtask

  // a full vector of random data; sometimes short, sometimes overfilled
  task automatic send_vector(int n);
    int cnt;
    cnt = n;
    case ($urandom_range(0, 5))
      0: cnt = $urandom_range(1, n);
      1: cnt = n + $urandom_range(1, 3);
      default: ;
    endcase
    for (int i = 0; i < cnt; i++)
      send(1, 3'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
           32'($urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 40)) - 20),
           $urandom, i == cnt - 1);
  endtask

  initial begin
    int sz;
    beats = 0; quiet = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: full coefficient set, ignored out-of-range level, full vector with extremes
    load_coefs(0);
    send(0, 3'd7, bbt_pkg::MAT_A, 0, 16'h8000, 0, 0, 0);
    send(0, 3'd6, bbt_pkg::MAT_DIV, 0, 16'h7fff, 0, 0, 0);
    for (int i = 0; i < 64; i++) begin
      case (i)
        0:  send(1, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0);
        1:  send(1, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
        63: send(1, 0, 0, 0, 0, 32'hffffffff, 32'h0, 1);
        default: send(1, 0, 0, 0, 0, $urandom, $urandom, 0);
      endcase
    end
    drain();
    write_reg(bbt_pkg::REG_SIZE, 3'd1);
    send(1, 0, 0, 0, 0, 32'h80000000, 32'hffffffff, 0);
    send(1, 0, 0, 0, 0, 32'h80000000, 32'h12345678, 1);
    drain();
    write_reg(bbt_pkg::REG_SIZE, 3'd7);
    write_reg(bbt_pkg::REG_MODE, 3'd1);
    send(0, 0, bbt_pkg::MAT_DIV, 0, 16'hffff, 0, 0, 0);
    send(0, 0, bbt_pkg::MAT_C, 0, 16'h7fff, 0, 0, 0);
    send(1, 0, 0, 0, 0, 32'h80000000, 0, 1);
    drain();
    write_reg(bbt_pkg::REG_SIZE, 3'd0);
    send(1, 0, 0, 0, 0, 32'h1234, 32'h5678, 1);
    drain();
    write_reg(bbt_pkg::REG_SIZE, 3'd1);
    send(0, 0, bbt_pkg::MAT_DIV, 0, 16'h0000, 0, 0, 0);
    send(1, 0, 0, 0, 0, 32'd7, 0, 0);
    send(1, 0, 0, 0, 0, -32'd9, 0, 1);
    drain();
    // random phases
    for (int ph = 0; beats < 300; ph++) begin
      if (beats > 260) quiet = 1;
      sz = (ph % 7 == 6) ? $urandom_range(6, 7) : $urandom_range(0, 3);
      write_reg(bbt_pkg::REG_SIZE, 3'(sz));
      write_reg(bbt_pkg::REG_MODE, 3'($urandom_range(0, 1)));
      if (ph % 4 == 0) load_coefs(ph % 8 == 4);
      load_divs(ph % 2 == 1);
      for (int v = 0; v < 2; v++) send_vector(1 << ((sz > 6) ? 6 : sz));
      drain();
    end
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end
endmodule
